// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL of the edit distance engine.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ED_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`define ED_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`else
`define ED_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define ED_ASSERT_NOW(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/ede_pkg.sv -----
// Types and constants of the edit distance engine.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package ede_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam int ACT_W       = 2;
    localparam int SYM_W       = 8;
    localparam int DIST_W      = 7;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD   = 2'd0,
        ACT_SOURCE = 2'd1,
        ACT_QUERY  = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_PASS  = 3'b010,
        S_QUERY = 3'b100
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;       // append pattern byte
        logic drop;       // set overflow flag
        logic src_start;  // open a row pass
        logic step;       // one column of the row pass
        logic rd_query;   // address the last row entry
        logic emit;       // latch result and clear
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic pat_ok;
        logic src_ok;
        logic len_zero;
        logic step_last;
    } t_status;

endpackage

// ----- src/ede_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ede_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/ede_ctrl.sv -----
// Controller of the edit distance engine: decodes words and sequences row passes.
// Depends on ede_pkg.
`timescale 1ns / 1ps
module ede_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [ede_pkg::ACT_W-1:0]      i_action,
    input  ede_pkg::t_status               i_status,
    output logic                           o_busy,
    output ede_pkg::t_cmd                  o_cmd
);
    import ede_pkg::*;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_action)
                        ACT_LOAD: begin
                            if (i_status.pat_ok) begin
                                o_cmd.load = 1'b1;
                            end else begin
                                o_cmd.drop = 1'b1;
                            end
                        end
                        ACT_SOURCE: begin
                            if (i_status.src_ok) begin
                                o_cmd.src_start = 1'b1;
                                if (!i_status.len_zero) begin
                                    n_state = S_PASS;
                                end
                            end else begin
                                o_cmd.drop = 1'b1;
                            end
                        end
                        ACT_QUERY: begin
                            o_cmd.rd_query = 1'b1;
                            n_state        = S_QUERY;
                        end
                        default: begin
                            // unused code: ignore the word
                        end
                    endcase
                end
            end
            S_PASS: begin
                o_cmd.step = 1'b1;
                if (i_status.step_last) begin
                    n_state = S_IDLE;
                end
            end
            S_QUERY: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- src/ede_datapath.sv -----
// Datapath of the edit distance engine: pattern and row memories, counters,
// one DP column per step, result register. Depends on ede_pkg and ede_ram.
`timescale 1ns / 1ps
module ede_datapath #(
    parameter int MAX_LEN = ede_pkg::MAX_LEN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [ede_pkg::SYM_W-1:0]      i_symbol,
    input  ede_pkg::t_cmd                  i_cmd,
    output ede_pkg::t_status               o_status,
    output logic                           o_strobe,
    output logic [ede_pkg::DIST_W-1:0]     o_distance,
    output logic                           o_overflow
);
    import ede_pkg::*;

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    // control state
    logic [LW-1:0]     r_len, n_len;
    logic [LW-1:0]     r_src, n_src;
    logic              r_drop, n_drop;
    logic [LW-1:0]     r_row0, n_row0;
    logic              r_valid, n_valid;
    // payload
    logic [LW-1:0]     r_left, n_left;
    logic [LW-1:0]     r_diag, n_diag;
    logic [AW-1:0]     r_j, n_j;
    logic [SYM_W-1:0]  r_sym, n_sym;
    logic [DIST_W-1:0] r_dist, n_dist;

    logic [SYM_W-1:0]  rd_pat;
    logic [LW-1:0]     rd_row;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     row_waddr;
    logic [LW-1:0]     row_wdata;
    logic [LW-1:0]     j_next;
    logic [LW:0]       above_inc, left_inc, diag_cost, min_ab, step_full;
    logic [LW-1:0]     step_val;
    logic [LW-1:0]     dist_val;
    logic [LW+DIST_W-1:0] dist_ext;

    assign j_next = LW'(r_j) + LW'(1);

    // row entry j+1 sits at RAM address j; entry zero is r_row0
    assign rd_addr   = i_cmd.step     ? AW'(j_next)
                     : i_cmd.rd_query ? AW'(r_len - LW'(1))
                     : '0;
    assign row_waddr = i_cmd.load ? AW'(r_len) : r_j;
    assign row_wdata = i_cmd.load ? (r_len + LW'(1)) : step_val;

    ede_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load),
        .i_waddr (AW'(r_len)),
        .i_wdata (i_symbol),
        .i_raddr (rd_addr),
        .o_rdata (rd_pat)
    );

    ede_ram #(.WIDTH(LW), .DEPTH(MAX_LEN)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load | i_cmd.step),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rd_row)
    );

    // one DP column: min of above+1, left+1, diag+cost
    always_comb begin
        above_inc = {1'b0, rd_row} + (LW+1)'(1);
        left_inc  = {1'b0, r_left} + (LW+1)'(1);
        diag_cost = {1'b0, r_diag} + (LW+1)'(rd_pat != r_sym);
        min_ab    = (above_inc < left_inc) ? above_inc : left_inc;
        step_full = (min_ab < diag_cost) ? min_ab : diag_cost;
        step_val  = step_full[LW-1:0];
    end

    assign dist_val = (r_len == '0) ? r_row0 : rd_row;
    assign dist_ext = {{DIST_W{1'b0}}, dist_val};

    always_comb begin
        n_len   = r_len;
        n_src   = r_src;
        n_drop  = r_drop;
        n_row0  = r_row0;
        n_valid = 1'b0;
        n_left  = r_left;
        n_diag  = r_diag;
        n_j     = r_j;
        n_sym   = r_sym;
        n_dist  = r_dist;
        if (i_cmd.load) begin
            n_len = r_len + LW'(1);
        end
        if (i_cmd.drop) begin
            n_drop = 1'b1;
        end
        if (i_cmd.src_start) begin
            n_src  = r_src + LW'(1);
            n_row0 = r_src + LW'(1);
            n_left = r_src + LW'(1);
            n_diag = r_row0;
            n_j    = '0;
            n_sym  = i_symbol;
        end
        if (i_cmd.step) begin
            n_left = step_val;
            n_diag = rd_row;
            n_j    = r_j + AW'(1);
        end
        if (i_cmd.emit) begin
            n_dist  = dist_ext[DIST_W-1:0];
            n_valid = 1'b1;
            n_len   = '0;
            n_src   = '0;
            n_drop  = 1'b0;
            n_row0  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_src   <= '0;
            r_drop  <= 1'b0;
            r_row0  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_len   <= n_len;
            r_src   <= n_src;
            r_drop  <= n_drop;
            r_row0  <= n_row0;
            r_valid <= n_valid;
        end
    end

    // overflow is sampled with the distance, before the clear
    logic r_ovf;

    always_ff @(posedge i_clk) begin
        r_left <= n_left;
        r_diag <= n_diag;
        r_j    <= n_j;
        r_sym  <= n_sym;
        r_dist <= n_dist;
        if (i_cmd.emit) begin
            r_ovf <= r_drop;
        end
    end

    assign o_status.pat_ok    = (r_src == '0) && (r_len != LW'(MAX_LEN));
    assign o_status.src_ok    = (r_src != LW'(MAX_LEN));
    assign o_status.len_zero  = (r_len == '0);
    assign o_status.step_last = (j_next == r_len);

    assign o_strobe   = r_valid;
    assign o_distance = r_dist;
    assign o_overflow = r_ovf;

endmodule

// ----- src/edit_distance_engine_top.sv -----
// Top level of the edit distance engine: controller plus datapath.
// Depends on ede_pkg, ede_ctrl, ede_datapath and assert_macros.svh.
`timescale 1ns / 1ps
// Levenshtein distance engine, unit costs, exact byte compare. A word is
// taken when start is high and busy is low. A load word leaves busy low.
// A source word steps one DP column per cycle in the pass state, set by
// the single read port of the row memory, so busy stays high while the
// columns of the pattern are stepped. A query word keeps busy high for
// one cycle and its result appears on o_distance/o_overflow with o_strobe
// high for exactly one cycle, registered after the query state; the result
// must be captured then, since it cannot be held off. Action code 3 is
// ignored. No clearing pass is needed after reset.
module edit_distance_engine_top #(
    parameter int MAX_LEN = ede_pkg::MAX_LEN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [ede_pkg::ACT_W-1:0]      i_action,
    input  logic [ede_pkg::SYM_W-1:0]      i_symbol,
    output logic                           o_strobe,
    output logic [ede_pkg::DIST_W-1:0]     o_distance,
    output logic                           o_overflow
);
    import ede_pkg::*;

    t_cmd    cmd;
    t_status status;

    ede_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_action),
        .i_status (status),
        .o_busy   (busy),
        .o_cmd    (cmd)
    );

    ede_datapath #(.MAX_LEN(MAX_LEN)) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_symbol   (i_symbol),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_strobe   (o_strobe),
        .o_distance (o_distance),
        .o_overflow (o_overflow)
    );

`include "assert_macros.svh"

    `ED_ASSERT_NEXT(a_emit_strobe, i_clk, i_rst_n, cmd.emit, o_strobe)
    `ED_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_strobe, !o_strobe)
    `ED_ASSERT_NEXT(a_empty_pass, i_clk, i_rst_n, start && !busy && i_action == ACT_SOURCE && status.len_zero, !busy)
    `ED_ASSERT_NOW(a_strobe_after_busy, i_clk, i_rst_n, o_strobe, $past(busy))

endmodule
